/* rtl/core/deq_pkg.sv */
// shared types and codes for the double-ended queue
package deq_pkg;

    // command codes
    localparam logic [2:0] CMD_PUSH_HEAD = 3'd0;
    localparam logic [2:0] CMD_PUSH_TAIL = 3'd1;
    localparam logic [2:0] CMD_POP_HEAD  = 3'd2;
    localparam logic [2:0] CMD_POP_TAIL  = 3'd3;
    localparam logic [2:0] CMD_PEEK_HEAD = 3'd4;
    localparam logic [2:0] CMD_PEEK_TAIL = 3'd5;

    // field widths fixed by the interface
    localparam int WORD_W  = 32;
    localparam int COUNT_W = 11;

    // result status
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } deq_status_t;

    // command transfer
    typedef struct packed {
        logic [2:0]               command;
        logic signed [WORD_W-1:0] data;
    } deq_req_t;

    // result transfer
    typedef struct packed {
        deq_status_t              status;
        logic signed [WORD_W-1:0] value;
        logic [COUNT_W-1:0]       count;
        logic                     is_empty;
    } deq_rsp_t;

endpackage

/* rtl/core/deq_store.sv */
// word store: one write port, one read port with registered read data
module deq_store #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [ADDR_W-1:0]          wr_addr,
    input  logic [deq_pkg::WORD_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [ADDR_W-1:0]          rd_addr,
    output logic [deq_pkg::WORD_W-1:0] rd_data
);

    logic [deq_pkg::WORD_W-1:0] mem [DEPTH];
    logic [deq_pkg::WORD_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/double_ended_queue.sv */
// double-ended queue of signed words in a ring store with front/back pointers
// a result passes the read stage and then the output register before it is offered
// throughput: one command per cycle while req_stall is low; the store write and the
//   registered read both happen at the command transfer, so the next command already sees the new state
// reset: pointers and count cleared, the deque is empty; store contents undefined
module double_ended_queue #(
    parameter int CAPACITY = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  deq_pkg::deq_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output deq_pkg::deq_rsp_t rsp
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

    // pointer and count state
    logic [IDX_W-1:0] front_reg, front_next;
    logic [IDX_W-1:0] back_reg, back_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // read stage: holds the command until the registered store data is available
    logic                 pend_valid_reg, pend_valid_next;
    deq_pkg::deq_status_t pend_status_reg, pend_status_next;
    logic                 pend_use_rd_reg, pend_use_rd_next;
    logic [CNT_W-1:0]     pend_count_reg, pend_count_next;

    // output register
    logic              rsp_valid_reg, rsp_valid_next;
    deq_pkg::deq_rsp_t rsp_reg, rsp_next;

    logic                       accept;
    logic                       pend_move;
    logic                       is_full, is_empty_now;
    logic [IDX_W-1:0]           front_inc, front_dec, back_inc, back_dec;
    logic                       wr_en;
    logic [IDX_W-1:0]           wr_addr;
    logic [IDX_W-1:0]           rd_addr;
    logic [deq_pkg::WORD_W-1:0] rd_data;
    logic [CNT_W+deq_pkg::COUNT_W-1:0] count_ext;

    // handshakes
    assign pend_move = pend_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = pend_valid_reg && rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;

    // ring pointer neighbors
    assign front_inc = (front_reg == IDX_LAST) ? '0 : front_reg + IDX_W'(1);
    assign front_dec = (front_reg == '0) ? IDX_LAST : front_reg - IDX_W'(1);
    assign back_inc  = (back_reg == IDX_LAST) ? '0 : back_reg + IDX_W'(1);
    assign back_dec  = (back_reg == '0) ? IDX_LAST : back_reg - IDX_W'(1);

    assign is_full      = (count_reg == CNT_FULL);
    assign is_empty_now = (count_reg == '0);

    // command decode: pointer, count and store updates
    always_comb
    begin
        front_next       = front_reg;
        back_next        = back_reg;
        count_next       = count_reg;
        wr_en            = 1'b0;
        wr_addr          = back_reg;
        rd_addr          = front_reg;
        pend_status_next = deq_pkg::ST_OK;
        pend_use_rd_next = 1'b0;
        unique case (req.command)
            deq_pkg::CMD_PUSH_HEAD:
            begin
                wr_addr = front_dec;
                if (is_full)
                begin
                    pend_status_next = deq_pkg::ST_FULL;
                end
                else
                begin
                    wr_en      = accept;
                    front_next = front_dec;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            deq_pkg::CMD_PUSH_TAIL:
            begin
                wr_addr = back_reg;
                if (is_full)
                begin
                    pend_status_next = deq_pkg::ST_FULL;
                end
                else
                begin
                    wr_en      = accept;
                    back_next  = back_inc;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            deq_pkg::CMD_POP_HEAD:
            begin
                rd_addr = front_reg;
                if (is_empty_now)
                begin
                    pend_status_next = deq_pkg::ST_EMPTY;
                end
                else
                begin
                    pend_use_rd_next = 1'b1;
                    front_next       = front_inc;
                    count_next       = count_reg - CNT_W'(1);
                end
            end
            deq_pkg::CMD_POP_TAIL:
            begin
                rd_addr = back_dec;
                if (is_empty_now)
                begin
                    pend_status_next = deq_pkg::ST_EMPTY;
                end
                else
                begin
                    pend_use_rd_next = 1'b1;
                    back_next        = back_dec;
                    count_next       = count_reg - CNT_W'(1);
                end
            end
            deq_pkg::CMD_PEEK_HEAD:
            begin
                rd_addr = front_reg;
                if (is_empty_now)
                begin
                    pend_status_next = deq_pkg::ST_EMPTY;
                end
                else
                begin
                    pend_use_rd_next = 1'b1;
                end
            end
            deq_pkg::CMD_PEEK_TAIL:
            begin
                rd_addr = back_dec;
                if (is_empty_now)
                begin
                    pend_status_next = deq_pkg::ST_EMPTY;
                end
                else
                begin
                    pend_use_rd_next = 1'b1;
                end
            end
            default:
            begin
                pend_status_next = deq_pkg::ST_OK;
            end
        endcase
        pend_count_next = count_next;
    end

    // word store
    deq_store #(
        .DEPTH  (CAPACITY),
        .ADDR_W (IDX_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (req.data),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // stage valid flags
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        if (accept)
        begin
            pend_valid_next = 1'b1;
        end
        else if (pend_move)
        begin
            pend_valid_next = 1'b0;
        end

        rsp_valid_next = rsp_valid_reg;
        if (pend_move)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // result assembly from the read stage
    assign count_ext = {{deq_pkg::COUNT_W{1'b0}}, pend_count_reg};

    always_comb
    begin
        rsp_next          = rsp_reg;
        if (pend_move)
        begin
            rsp_next.status   = pend_status_reg;
            rsp_next.value    = pend_use_rd_reg ? $signed(rd_data) : '0;
            rsp_next.count    = count_ext[deq_pkg::COUNT_W-1:0];
            rsp_next.is_empty = (pend_count_reg == '0);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg      <= '0;
            back_reg       <= '0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                front_reg <= front_next;
                back_reg  <= back_next;
                count_reg <= count_next;
            end
            pend_valid_reg <= pend_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_status_reg <= pend_status_next;
            pend_use_rd_reg <= pend_use_rd_next;
            pend_count_reg  <= pend_count_next;
        end
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // count never passes the capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("deque count above capacity");

    // an empty deque has both pointers on the same slot
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (front_reg == back_reg))
        else $error("pointers differ while empty");

    // an accepted command is held in the read stage next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> pend_valid_reg)
        else $error("accepted command lost");

    // a dropped push only happens on a non-empty deque
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.status == deq_pkg::ST_FULL) |-> !rsp_reg.is_empty)
        else $error("full status with empty deque");

endmodule
